// File: hdl/masked_event_queue_assert.svh
// Assertion macros for the masked event queue.
// No dependencies; taken in by `include in the files that assert.
`ifndef MASKED_EVENT_QUEUE_ASSERT_SVH
`define MASKED_EVENT_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define MEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MEQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/meq_pkg.sv
// Package for the masked event queue: word types, request codes, FSM states.
// No dependencies.
package meq_pkg;
	localparam int unsigned CAPACITY_DEF = 128;
	localparam int unsigned ENTRY_W = 4 + 32 + 32 + 16 + 16 + 16;

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_TAKE = 2'd1,
		REQ_PEEK = 2'd2,
		REQ_NONE = 2'd3
	} req_e;

	typedef struct packed {
		logic [3:0]         code;
		logic [31:0]        message;
		logic [31:0]        time_stamp;
		logic signed [15:0] h;
		logic signed [15:0] v;
		logic [15:0]        mods;
	} entry_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        event_mask;
		logic [3:0]         event_code;
		logic [31:0]        event_message;
		logic [31:0]        event_time;
		logic signed [15:0] event_h;
		logic signed [15:0] event_v;
		logic [15:0]        event_mods;
	} req_word_t;

	typedef struct packed {
		logic               found;
		logic [3:0]         out_code;
		logic [31:0]        out_message;
		logic [31:0]        out_time;
		logic signed [15:0] out_h;
		logic signed [15:0] out_v;
		logic [15:0]        out_mods;
		logic               dropped;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;
endpackage

// File: hdl/meq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module meq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/masked_event_queue.sv
// Masked event queue: an arrival-ordered bounded queue with masked take/peek.
// Depends on meq_pkg, meq_ram and masked_event_queue_assert.svh.
// The result strobe comes in the cycle after the last working cycle, and the
// queue is idle again in the cycle after the strobe. A plain push goes straight
// to the done state, where the word is written. A push into a full queue first
// drops the oldest word and shifts the rest down. A take or peek scans the
// stored words one a cycle through the RAM read port until the first match or the
// end of the queue; a take then shifts the later words down one place. The
// slowest request is a take that finds a match in a full queue.
// busy is high from acceptance until the result strobe; results cannot be stalled.
`include "masked_event_queue_assert.svh"
module masked_event_queue import meq_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_word_t req,
	output logic      busy,
	output logic      done,
	output res_word_t result
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t     state_q, state_d;
	req_word_t  req_q;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;     // read address in flight
	logic       rvalid_q, rvalid_d;  // read data valid this cycle
	logic [CW-1:0] ridx_q, ridx_d;   // address of read data
	logic       push_q, push_d;      // push pending, written in the done state
	res_word_t  res_q, res_d;
	logic       we;
	logic [AW-1:0] waddr, raddr;
	entry_t     wdata, rdata;
	logic       match;

	meq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign raddr = idx_q[AW-1:0];
	assign match = req_q.event_mask[rdata.code];
	assign busy  = (state_q != ST_IDLE);
	assign result = res_q;
	assign done  = (state_q == ST_DONE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rvalid_q <= 1'b0;
			push_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rvalid_q <= rvalid_d;
			push_q   <= push_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		idx_q  <= idx_d;
		ridx_q <= ridx_d;
		res_q  <= res_d;
	end

	// Sequencer: scan reads idx, compares in the next cycle; shift copies ridx to ridx-1
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		ridx_d   = idx_q;
		rvalid_d = 1'b0;
		push_d   = push_q;
		res_d    = res_q;
		we       = 1'b0;
		waddr    = count_q[AW-1:0];
		wdata    = '{code: req_q.event_code, message: req_q.event_message,
			time_stamp: req_q.event_time, h: req_q.event_h, v: req_q.event_v,
			mods: req_q.event_mods};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_d = '0;
					push_d = 1'b0;
					case (req_e'(req.req_type))
						REQ_PUSH: begin
							if (count_q == CAP_C) begin
								res_d.dropped = 1'b1;
								push_d   = 1'b1;
								idx_d    = CW'(1);
								rvalid_d = 1'b0;
								state_d  = ST_SHIFT;
							end else begin
								push_d  = 1'b1;
								state_d = ST_DONE;
							end
						end
						REQ_TAKE, REQ_PEEK: begin
							idx_d   = '0;
							state_d = ST_SCAN;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				// issue next read, check previous
				if (rvalid_q && match) begin
					res_d.found       = 1'b1;
					res_d.out_code    = rdata.code;
					res_d.out_message = rdata.message;
					res_d.out_time    = rdata.time_stamp;
					res_d.out_h       = rdata.h;
					res_d.out_v       = rdata.v;
					res_d.out_mods    = rdata.mods;
					if (req_e'(req_q.req_type) == REQ_TAKE) begin
						idx_d   = ridx_q + CW'(1);
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_DONE;
					end
				end else if (idx_q >= count_q) begin
					if (!rvalid_q) state_d = ST_DONE;
				end else begin
					rvalid_d = 1'b1;
					idx_d    = idx_q + CW'(1);
				end
				if (state_d == ST_SCAN && idx_q >= count_q && rvalid_q) begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				// write word read last cycle one place down
				if (rvalid_q) begin
					we    = 1'b1;
					waddr = AW'(ridx_q - CW'(1));
					wdata = rdata;
				end
				if (idx_q < count_q) begin
					rvalid_d = 1'b1;
					idx_d    = idx_q + CW'(1);
				end else if (!rvalid_q || idx_q == count_q) begin
					if (!(idx_q < count_q) && rvalid_q) begin
						count_d = count_q - CW'(1);
						state_d = ST_DONE;
					end else if (!rvalid_q) begin
						count_d = count_q - CW'(1);
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (push_q) begin
					we      = 1'b1;
					waddr   = count_q[AW-1:0];
					count_d = count_q + CW'(1);
					push_d  = 1'b0;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`MEQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP_C, "count beyond capacity")
	`MEQ_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy, "done not followed by idle")
	`MEQ_ASSERT_IMP(a_drop_push, clk, arst_n, done && result.dropped, !result.found, "drop with found")
	`MEQ_ASSERT_IMP(a_push_room, clk, arst_n, done && push_q, count_q < CAP_C, "push into full queue")
endmodule

// File: sim/tb_masked_event_queue.sv
`timescale 1ns / 1ps
// Testbench for masked_event_queue: directed and random push/take/peek words
// checked against an arrival-ordered queue predictor. Depends on meq_pkg and the RTL.
module tb_masked_event_queue;
	import meq_pkg::*;

	localparam int CAP = CAPACITY_DEF;

	logic      clk;
	logic      arst_n;
	logic      start;
	req_word_t req;
	logic      busy;
	logic      done;
	res_word_t result;

	masked_event_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	// Predictor state: stored events, index 0 oldest
	entry_t    held_events[$];
	res_word_t expected_words[$];
	int        mismatch_count;
	int        words_sent;
	int        words_checked;
	int        drops_seen;
	int        hits_seen;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [127:0] got,
			input logic [127:0] want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// Compute the result of one request and update the held events
	function automatic res_word_t predict_word(input req_word_t r);
		res_word_t w;
		entry_t    e;
		w = '0;
		case (req_e'(r.req_type))
			REQ_PUSH: begin
				if (held_events.size() >= CAP) begin
					held_events.delete(0);
					w.dropped = 1'b1;
				end
				e.code = r.event_code;
				e.message = r.event_message;
				e.time_stamp = r.event_time;
				e.h = r.event_h;
				e.v = r.event_v;
				e.mods = r.event_mods;
				held_events = {held_events, e};
			end
			REQ_TAKE, REQ_PEEK: begin
				for (int i = 0; i < held_events.size(); i++) begin
					if (r.event_mask[held_events[i].code]) begin
						w.found = 1'b1;
						w.out_code = held_events[i].code;
						w.out_message = held_events[i].message;
						w.out_time = held_events[i].time_stamp;
						w.out_h = held_events[i].h;
						w.out_v = held_events[i].v;
						w.out_mods = held_events[i].mods;
						if (r.req_type == REQ_TAKE)
							held_events.delete(i);
						break;
					end
				end
			end
			default: ;
		endcase
		return w;
	endfunction

	// Send one word after a random gap; predict on acceptance.
	// start stays high across a zero gap, so it is driven once per edge.
	task automatic send_word(input req_word_t r);
		int        gap;
		res_word_t w;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		w = predict_word(r);
		expected_words = {expected_words, w};
		words_sent++;
	endtask

	function automatic req_word_t make_word(input req_e kind, input logic [15:0] mask,
			input logic [3:0] code);
		req_word_t r;
		r.req_type = kind;
		r.event_mask = mask;
		r.event_code = code;
		r.event_message = $urandom;
		r.event_time = $urandom;
		r.event_h = 16'($urandom);
		r.event_v = 16'($urandom);
		r.event_mods = 16'($urandom);
		return r;
	endfunction

	// Check each result strobe against the oldest expectation
	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", result, '0);
			end else begin
				want = expected_words[0];
				expected_words.delete(0);
				words_checked++;
				if (want.dropped) drops_seen++;
				if (want.found) hits_seen++;
				if (result.found !== want.found)
					report_mismatch("found", result.found, want.found);
				if (result.out_code !== want.out_code)
					report_mismatch("out_code", result.out_code, want.out_code);
				if (result.out_message !== want.out_message)
					report_mismatch("out_message", result.out_message, want.out_message);
				if (result.out_time !== want.out_time)
					report_mismatch("out_time", result.out_time, want.out_time);
				if (result.out_h !== want.out_h)
					report_mismatch("out_h", result.out_h, want.out_h);
				if (result.out_v !== want.out_v)
					report_mismatch("out_v", result.out_v, want.out_v);
				if (result.out_mods !== want.out_mods)
					report_mismatch("out_mods", result.out_mods, want.out_mods);
				if (result.dropped !== want.dropped)
					report_mismatch("dropped", result.dropped, want.dropped);
			end
		end
	end

	// Empty queue, field extremes, every request code, empty and full masks
	task automatic test_directed();
		req_word_t r;
		send_word(make_word(REQ_TAKE, 16'hFFFF, 4'd0));
		send_word(make_word(REQ_PEEK, 16'hFFFF, 4'd0));
		r = make_word(REQ_PUSH, 16'h0, 4'd15);
		r.event_message = '1; r.event_time = '1;
		r.event_h = 16'sh7FFF; r.event_v = -16'sh8000; r.event_mods = '1;
		send_word(r);
		r = make_word(REQ_PUSH, 16'hFFFF, 4'd0);
		r.event_message = '0; r.event_time = '0;
		r.event_h = -16'sh8000; r.event_v = 16'sh7FFF; r.event_mods = '0;
		send_word(r);
		send_word(make_word(REQ_PEEK, 16'h0000, 4'd0));
		send_word(make_word(REQ_PEEK, 16'h0001, 4'd0));
		send_word(make_word(REQ_NONE, 16'hFFFF, 4'd3));
		send_word(make_word(REQ_TAKE, 16'h8000, 4'd0));
		send_word(make_word(REQ_TAKE, 16'h8000, 4'd0));
		send_word(make_word(REQ_TAKE, 16'hFFFF, 4'd0));
		send_word(make_word(REQ_TAKE, 16'hFFFF, 4'd0));
	endtask

	// Fill past capacity so the oldest events are dropped, then drain a few
	task automatic test_overflow();
		for (int i = 0; i < CAP + 6; i++)
			send_word(make_word(REQ_PUSH, 16'h0, 4'($urandom)));
		for (int i = 0; i < 8; i++)
			send_word(make_word(REQ_TAKE, 16'($urandom), 4'd0));
		send_word(make_word(REQ_TAKE, 16'h8000, 4'd0));
	endtask

	// Random mix: mostly pushes and selective takes, some peeks and unused codes
	task automatic test_random(input int count);
		int pick;
		logic [15:0] mask;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0: mask = 16'hFFFF;
				1: mask = 16'(1 << $urandom_range(0, 15));
				default: mask = 16'($urandom);
			endcase
			if (pick < 48)
				send_word(make_word(REQ_PUSH, 16'($urandom), 4'($urandom)));
			else if (pick < 80)
				send_word(make_word(REQ_TAKE, mask, 4'($urandom)));
			else if (pick < 96)
				send_word(make_word(REQ_PEEK, mask, 4'($urandom)));
			else
				send_word(make_word(REQ_NONE, 16'($urandom), 4'($urandom)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		mismatch_count = 0;
		words_sent = 0;
		words_checked = 0;
		drops_seen = 0;
		hits_seen = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random(1550);
		start <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d words, %0d results checked: %0d hits, %0d drops.",
			words_sent, words_checked, hits_seen, drops_seen);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: fails the run if it hangs; the slowest run is under 1800 words
	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+hdl
hdl/meq_pkg.sv
hdl/meq_ram.sv
hdl/masked_event_queue.sv
sim/tb_masked_event_queue.sv
